[src/bli_pkg.sv]
`timescale 1ns / 1ps
package bli_pkg;

   // fixed field and datapath widths
   localparam int POS_W   = 20;
   localparam int D_W     = 21;
   localparam int SQ_W    = 41;
   localparam int RAD_W   = 42;
   localparam int ROOT_W  = 21;
   localparam int DIV_W   = 21;
   localparam int QBITS   = 30;
   localparam int T_W     = 32;
   localparam int AROOT_W = 31;
   localparam int ARAD_W  = 62;
   localparam int CORD_W  = 34;
   localparam int ACC_W   = 40;
   localparam int ANG_W   = 19;
   localparam int CSR_W   = 20;
   localparam int NRATIO  = 4;

   // fixed stages ahead of and behind the cordic row
   localparam int FRONT_STAGES = 4 + ROOT_W + 1 + QBITS + 1 + 2 + AROOT_W;
   localparam int BACK_STAGES  = 3;

   // leg mode codes
   localparam logic [1:0] MODE_OFFSET = 2'd0;
   localparam logic [1:0] MODE_HUMAN  = 2'd2;

   // register map
   typedef enum logic [2:0] {
      CSR_LEG_MODE = 3'd0,
      CSR_HIP_X    = 3'd1,
      CSR_HIP_Y    = 3'd2,
      CSR_HIP_Z    = 3'd3,
      CSR_LINK     = 3'd4,
      CSR_LATERAL  = 3'd5
   } csr_index_type;

   // angles in q30 radians
   localparam logic signed [ACC_W-1:0] Q30_PI      = 40'sd3373259426;
   localparam logic signed [ACC_W-1:0] Q30_HALF_PI = 40'sd1686629713;
   localparam logic [ARAD_W-1:0]       Q60_ONE     = 62'd1 << 60;
   localparam logic [AROOT_W-1:0]      Q30_ONE     = 31'd1 << 30;

   localparam logic signed [ANG_W:0] OUT_MAX = 20'sd262143;
   localparam logic signed [ANG_W:0] OUT_MIN = -20'sd262144;

   function automatic int bli_latency(input int cordic_stages);
      return FRONT_STAGES + cordic_stages + BACK_STAGES;
   endfunction

   // floor arctangent of 2^-idx in q30
   function automatic logic [29:0] bli_atan(input int idx);
      logic [29:0] v;
      unique case (idx)
         0:  v = 30'd843314856;
         1:  v = 30'd497837829;
         2:  v = 30'd263043836;
         3:  v = 30'd133525158;
         4:  v = 30'd67021686;
         5:  v = 30'd33543515;
         6:  v = 30'd16775850;
         7:  v = 30'd8388437;
         8:  v = 30'd4194282;
         9:  v = 30'd2097149;
         10: v = 30'd1048575;
         11: v = 30'd524287;
         12: v = 30'd262143;
         13: v = 30'd131071;
         14: v = 30'd65535;
         15: v = 30'd32767;
         16: v = 30'd16383;
         17: v = 30'd8191;
         18: v = 30'd4095;
         19: v = 30'd2047;
         20: v = 30'd1023;
         21: v = 30'd511;
         22: v = 30'd255;
         23: v = 30'd127;
         24: v = 30'd63;
         25: v = 30'd31;
         26: v = 30'd15;
         27: v = 30'd7;
         28: v = 30'd3;
         29: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   // clip to the signed angle range
   function automatic logic signed [ANG_W-1:0] bli_sat(input logic signed [ACC_W:0] v);
      logic signed [ANG_W-1:0] r;
      priority if (v > ACC_W'(OUT_MAX)) r = OUT_MAX[ANG_W-1:0];
      else if (v < ACC_W'(OUT_MIN)) r = OUT_MIN[ANG_W-1:0];
      else r = v[ANG_W-1:0];
      return r;
   endfunction

endpackage

[src/biped_leg_inverse_kinematics.sv]
`timescale 1ns / 1ps
// Five-joint biped leg inverse kinematics, fully pipelined.
//
// Input: a beat is taken at each clock edge with start high and busy low.
// busy stays low, so a new foot target may enter every cycle.
// Output: each result is on the rsp_ ports for one cycle, marked by
// rsp_valid; results leave in input order and the receiver cannot stall.
// Pipeline, in order: 4 setup stages, a 21-cell root row, a ratio setup
// stage, a 30-cell divider row, a sign stage, then inside each arcsine
// lane 2 stages for 1 - t^2, a 31-cell cosine root row and the cordic
// row, and 3 output stages.
// Throughput: one beat per cycle.
// Configuration: csr_we writes register csr_index with csr_wdata at once;
// write only while no beat is in flight.
// Reset (synchronous, active high) clears the in-flight markers and loads
// the register defaults; beats in flight at reset are dropped.
module biped_leg_inverse_kinematics
   import bli_pkg::*;
#(
   parameter int POS_FRAC_BITS   = 16,
   parameter int ANGLE_FRAC_BITS = 14,
   parameter int CORDIC_STAGES   = 18
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [POS_W-1:0] req_foot_x,
   input  logic signed [POS_W-1:0] req_foot_y,
   input  logic signed [POS_W-1:0] req_foot_z,
   input  logic                    req_leg_side,
   output logic                    rsp_valid,
   output logic signed [ANG_W-1:0] rsp_hip_yaw_angle,
   output logic signed [ANG_W-1:0] rsp_leg_roll_angle,
   output logic signed [ANG_W-1:0] rsp_hip_pitch_angle,
   output logic signed [ANG_W-1:0] rsp_knee_angle,
   output logic signed [ANG_W-1:0] rsp_ankle_angle,
   output logic                    rsp_degenerate,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   localparam int LAT = bli_latency(CORDIC_STAGES);
   localparam logic [63:0] EPS64 = (64'd1 << (2 * POS_FRAC_BITS)) / 64'd100000;
   localparam logic signed [43:0] EPS = signed'(EPS64[43:0]);
   localparam int RND_SH = 30 - ANGLE_FRAC_BITS;
   localparam logic signed [ACC_W-1:0] RND_ADD = ACC_W'(64'd1 << (29 - ANGLE_FRAC_BITS));
   localparam int SBA_W = 4 + D_W;
   localparam int SBB_W = 3 + 3 * NRATIO;
   localparam int SBC_W = 3;
   localparam int SBC_DEPTH = 2 + AROOT_W + CORDIC_STAGES;

   // configuration registers
   logic [1:0]              leg_mode_ff;
   logic signed [POS_W-1:0] hip_x_ff, hip_y_ff, hip_z_ff;
   logic [15:0]             link_ff, lat_ff;
   logic                    mode_off, mode_hum;

   always_ff @(posedge clock) begin
      if (reset) begin
         leg_mode_ff <= MODE_OFFSET;
         hip_x_ff    <= '0;
         hip_y_ff    <= '0;
         hip_z_ff    <= '0;
         link_ff     <= 16'd14418;
         lat_ff      <= 16'd1180;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEG_MODE: leg_mode_ff <= csr_wdata[1:0];
            CSR_HIP_X:    hip_x_ff    <= signed'(csr_wdata);
            CSR_HIP_Y:    hip_y_ff    <= signed'(csr_wdata);
            CSR_HIP_Z:    hip_z_ff    <= signed'(csr_wdata);
            CSR_LINK:     link_ff     <= csr_wdata[15:0];
            CSR_LATERAL:  lat_ff      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // the unused fourth mode behaves as the human knee
   assign mode_off = leg_mode_ff == MODE_OFFSET;
   assign mode_hum = leg_mode_ff >= MODE_HUMAN;

   // in-flight markers
   logic           accept;
   logic [LAT-1:0] vld_ff, vld_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: offset from the hip roll origin
   logic signed [D_W-1:0] s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic                  s1_side_ff;

   always_ff @(posedge clock) begin
      s1_dx_ff   <= D_W'(req_foot_x) - D_W'(hip_x_ff);
      s1_dy_ff   <= D_W'(req_foot_y) - D_W'(hip_y_ff);
      s1_dz_ff   <= D_W'(req_foot_z) - D_W'(hip_z_ff);
      s1_side_ff <= req_leg_side;
   end

   // stage 2: squares
   logic signed [2*D_W-1:0] px, py, pz;
   logic [SQ_W-1:0]         s2_dx2_ff, s2_dy2_ff, s2_dz2_ff;
   logic [31:0]             s2_hh_ff;
   logic signed [D_W-1:0]   s2_dy_ff;
   logic                    s2_side_ff, s2_pos_ff, s2_neg_ff;

   assign px = s1_dx_ff * s1_dx_ff;
   assign py = s1_dy_ff * s1_dy_ff;
   assign pz = s1_dz_ff * s1_dz_ff;

   always_ff @(posedge clock) begin
      s2_dx2_ff  <= px[SQ_W-1:0];
      s2_dy2_ff  <= py[SQ_W-1:0];
      s2_dz2_ff  <= pz[SQ_W-1:0];
      s2_hh_ff   <= 32'(lat_ff) * 32'(lat_ff);
      s2_dy_ff   <= s1_dy_ff;
      s2_side_ff <= s1_side_ff;
      s2_pos_ff  <= !s1_dx_ff[D_W-1] && (s1_dx_ff != '0);
      s2_neg_ff  <= s1_dx_ff[D_W-1];
   end

   // stage 3: yz distance squared
   logic [RAD_W-1:0]      s3_ryz_ff;
   logic [SQ_W-1:0]       s3_dx2_ff;
   logic [31:0]           s3_hh_ff;
   logic signed [D_W-1:0] s3_dy_ff;
   logic                  s3_side_ff, s3_pos_ff, s3_neg_ff;

   always_ff @(posedge clock) begin
      s3_ryz_ff  <= {1'b0, s2_dy2_ff} + {1'b0, s2_dz2_ff};
      s3_dx2_ff  <= s2_dx2_ff;
      s3_hh_ff   <= s2_hh_ff;
      s3_dy_ff   <= s2_dy_ff;
      s3_side_ff <= s2_side_ff;
      s3_pos_ff  <= s2_pos_ff;
      s3_neg_ff  <= s2_neg_ff;
   end

   // stage 4: radicands of the three roots
   logic signed [43:0] rv, rx;
   logic [RAD_W-1:0]   rad_v_in, rad_xz_in;
   logic               deg4_in;
   logic [RAD_W-1:0]   s4_rad_ff [3];
   logic [SBA_W-1:0]   s4_sb_ff;

   always_comb begin
      rv = signed'({2'b00, s3_ryz_ff}) - signed'({12'd0, s3_hh_ff});
      rx = signed'({2'b00, s3_ryz_ff}) + signed'({3'b000, s3_dx2_ff})
         - (mode_off ? signed'({12'd0, s3_hh_ff}) : 44'sd0);
      if (mode_off) begin
         rad_v_in = (rv > EPS) ? rv[RAD_W-1:0] : EPS[RAD_W-1:0];
      end else begin
         rad_v_in = s3_ryz_ff;
      end
      rad_xz_in = (rx > 44'sd0) ? rx[RAD_W-1:0] : '0;
      deg4_in   = (s3_ryz_ff == '0) || !(rx > 44'sd0);
   end

   always_ff @(posedge clock) begin
      s4_rad_ff[0] <= s3_ryz_ff;
      s4_rad_ff[1] <= rad_v_in;
      s4_rad_ff[2] <= rad_xz_in;
      s4_sb_ff     <= {deg4_in, s3_side_ff, s3_pos_ff, s3_neg_ff, s3_dy_ff};
   end

   // root row: lanes yz, vertical, xz
   logic [RAD_W-1:0]  q_rad  [3][ROOT_W+1];
   logic [ROOT_W-1:0] q_rem  [3][ROOT_W+1];
   logic [ROOT_W-1:0] q_root [3][ROOT_W+1];
   logic [SBA_W-1:0]  sba_d;

   for (genvar l = 0; l < 3; l++) begin : g_root_lane
      assign q_rad[l][0]  = s4_rad_ff[l];
      assign q_rem[l][0]  = '0;
      assign q_root[l][0] = '0;
      for (genvar c = 0; c < ROOT_W; c++) begin : g_cell
         bli_sqrt_cell #(.RW(ROOT_W)) u_cell (
            .clock  (clock),
            .rad_i  (q_rad[l][c]),
            .rem_i  (q_rem[l][c]),
            .root_i (q_root[l][c]),
            .rad_o  (q_rad[l][c+1]),
            .rem_o  (q_rem[l][c+1]),
            .root_o (q_root[l][c+1])
         );
      end
   end

   bli_delay #(.W(SBA_W), .DEPTH(ROOT_W)) u_sba (
      .clock (clock),
      .d_i   (s4_sb_ff),
      .q_o   (sba_d)
   );

   // ratio setup: a1 = xz/2L, a2 = vert/xz, roll terms dy/yz and side*h/yz
   logic [ROOT_W-1:0]     yz, vert, xz;
   logic signed [D_W-1:0] a_dy;
   logic                  a_deg, a_side, a_pos, a_neg;
   logic [DIV_W-1:0]      p_den [NRATIO];
   logic [DIV_W-1:0]      p_an  [NRATIO];
   logic [NRATIO-1:0]     p_zero, p_clamp, p_sign;
   logic [DIV_W-1:0]      p_den_ff [NRATIO];
   logic [DIV_W-1:0]      p_an_ff  [NRATIO];
   logic [SBB_W-1:0]      p_sb_ff;

   always_comb begin
      yz   = q_root[0][ROOT_W];
      vert = q_root[1][ROOT_W];
      xz   = q_root[2][ROOT_W];
      {a_deg, a_side, a_pos, a_neg, a_dy} = sba_d;
      p_den[0] = {4'd0, link_ff, 1'b0};
      p_an[0]  = xz;
      p_den[1] = xz;
      p_an[1]  = vert;
      p_den[2] = yz;
      p_an[2]  = a_dy[D_W-1] ? DIV_W'(-a_dy) : DIV_W'(a_dy);
      p_den[3] = yz;
      p_an[3]  = DIV_W'(lat_ff);
      p_sign   = {!a_side, a_dy[D_W-1], 2'b00};
      for (int r = 0; r < NRATIO; r++) begin
         p_zero[r]  = p_den[r] == '0;
         p_clamp[r] = p_an[r] >= p_den[r];
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < NRATIO; r++) begin
         p_den_ff[r] <= p_den[r];
         p_an_ff[r]  <= p_an[r];
      end
      p_sb_ff <= {a_deg || p_zero[0] || p_zero[1] || p_zero[2] || (mode_off && p_zero[3]),
                  a_pos, a_neg, p_zero, p_clamp, p_sign};
   end

   // divider row: one quotient bit per cell
   logic [DIV_W-1:0] v_rem  [NRATIO][QBITS+1];
   logic [DIV_W-1:0] v_den  [NRATIO][QBITS+1];
   logic [QBITS-1:0] v_quot [NRATIO][QBITS+1];
   logic [SBB_W-1:0] sbb_d;

   for (genvar l = 0; l < NRATIO; l++) begin : g_div_lane
      assign v_rem[l][0]  = p_an_ff[l];
      assign v_den[l][0]  = p_den_ff[l];
      assign v_quot[l][0] = '0;
      for (genvar c = 0; c < QBITS; c++) begin : g_cell
         bli_div_cell #(.DW(DIV_W), .QW(QBITS)) u_cell (
            .clock  (clock),
            .rem_i  (v_rem[l][c]),
            .den_i  (v_den[l][c]),
            .quot_i (v_quot[l][c]),
            .rem_o  (v_rem[l][c+1]),
            .den_o  (v_den[l][c+1]),
            .quot_o (v_quot[l][c+1])
         );
      end
   end

   bli_delay #(.W(SBB_W), .DEPTH(QBITS)) u_sbb (
      .clock (clock),
      .d_i   (p_sb_ff),
      .q_o   (sbb_d)
   );

   // signed q30 ratio, clamped to one, zero on a zero divisor
   logic                  b_deg, b_pos, b_neg;
   logic [NRATIO-1:0]     b_zero, b_clamp, b_sign;
   logic [AROOT_W-1:0]    b_mag [NRATIO];
   logic signed [T_W-1:0] t_ff  [NRATIO];
   logic [SBC_W-1:0]      t_sb_ff;

   always_comb begin
      {b_deg, b_pos, b_neg, b_zero, b_clamp, b_sign} = sbb_d;
      for (int r = 0; r < NRATIO; r++) begin
         priority if (b_zero[r]) b_mag[r] = '0;
         else if (b_clamp[r]) b_mag[r] = Q30_ONE;
         else b_mag[r] = {1'b0, v_quot[r][QBITS]};
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < NRATIO; r++) begin
         t_ff[r] <= b_sign[r] ? -signed'(T_W'(b_mag[r])) : signed'(T_W'(b_mag[r]));
      end
      t_sb_ff <= {b_deg, b_pos, b_neg};
   end

   // arcsine lanes
   logic signed [CORD_W-1:0] z_asin [NRATIO];
   logic [SBC_W-1:0]         sbc_d;

   for (genvar l = 0; l < NRATIO; l++) begin : g_asin
      bli_asin_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_lane (
         .clock (clock),
         .t_i   (t_ff[l]),
         .z_o   (z_asin[l])
      );
   end

   bli_delay #(.W(SBC_W), .DEPTH(SBC_DEPTH)) u_sbc (
      .clock (clock),
      .d_i   (t_sb_ff),
      .q_o   (sbc_d)
   );

   // joint angles in q30
   logic signed [ACC_W-1:0] za1, za2, zr1, zr2, acos1, acos2, sacos2;
   logic signed [ACC_W-1:0] roll_ff, pitch_ff, knee_ff;
   logic signed [ACC_W-1:0] roll_in, pitch_in, knee_in;
   logic                    f1_deg_ff;

   always_comb begin
      za1    = ACC_W'(z_asin[0]);
      za2    = ACC_W'(z_asin[1]);
      zr1    = ACC_W'(z_asin[2]);
      zr2    = ACC_W'(z_asin[3]);
      acos1  = Q30_HALF_PI - za1;
      acos2  = Q30_HALF_PI - za2;
      roll_in = zr1 + (mode_off ? zr2 : '0);
      priority if (sbc_d[1]) sacos2 = acos2;
      else if (sbc_d[0]) sacos2 = -acos2;
      else sacos2 = '0;
      pitch_in = (mode_hum ? -acos1 : acos1) - sacos2;
      knee_in  = mode_hum ? (Q30_PI - (za1 <<< 1)) : ((za1 <<< 1) - Q30_PI);
   end

   always_ff @(posedge clock) begin
      roll_ff   <= roll_in;
      pitch_ff  <= pitch_in;
      knee_ff   <= knee_in;
      f1_deg_ff <= sbc_d[2];
   end

   // round half up to the output scale
   logic signed [ACC_W-1:0] roll_o_ff, pitch_o_ff, knee_o_ff;
   logic                    f2_deg_ff;

   always_ff @(posedge clock) begin
      roll_o_ff  <= (roll_ff + RND_ADD) >>> RND_SH;
      pitch_o_ff <= (pitch_ff + RND_ADD) >>> RND_SH;
      knee_o_ff  <= (knee_ff + RND_ADD) >>> RND_SH;
      f2_deg_ff  <= f1_deg_ff;
   end

   // ankle from the rounded values, then clip everything
   logic signed [ACC_W:0]    ankle_full;
   logic signed [ANG_W-1:0]  roll_out_ff, pitch_out_ff, knee_out_ff, ankle_out_ff;
   logic                     deg_out_ff;

   assign ankle_full = -(ACC_W+1)'(knee_o_ff) - (ACC_W+1)'(pitch_o_ff);

   always_ff @(posedge clock) begin
      roll_out_ff  <= bli_sat((ACC_W+1)'(roll_o_ff));
      pitch_out_ff <= bli_sat((ACC_W+1)'(pitch_o_ff));
      knee_out_ff  <= bli_sat((ACC_W+1)'(knee_o_ff));
      ankle_out_ff <= bli_sat(ankle_full);
      deg_out_ff   <= f2_deg_ff;
   end

   assign rsp_valid           = vld_ff[LAT-1];
   assign rsp_hip_yaw_angle   = '0;
   assign rsp_leg_roll_angle  = roll_out_ff;
   assign rsp_hip_pitch_angle = pitch_out_ff;
   assign rsp_knee_angle      = knee_out_ff;
   assign rsp_ankle_angle     = ankle_out_ff;
   assign rsp_degenerate      = deg_out_ff;

endmodule

[src/bli_delay.sv]
`timescale 1ns / 1ps
module bli_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic [W-1:0] d_i,
   output logic [W-1:0] q_o
);

   logic [W-1:0] line_ff [DEPTH];

   // shift line, one stage per cycle
   always_ff @(posedge clock) begin
      line_ff[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
         line_ff[k] <= line_ff[k-1];
      end
   end

   assign q_o = line_ff[DEPTH-1];

endmodule

[src/bli_sqrt_cell.sv]
`timescale 1ns / 1ps
module bli_sqrt_cell #(
   parameter int RW = 21
) (
   input  logic            clock,
   input  logic [2*RW-1:0] rad_i,
   input  logic [RW-1:0]   rem_i,
   input  logic [RW-1:0]   root_i,
   output logic [2*RW-1:0] rad_o,
   output logic [RW-1:0]   rem_o,
   output logic [RW-1:0]   root_o
);

   logic [RW+1:0]   rem_sh;
   logic [RW+1:0]   trial;
   logic            take;
   logic [RW+1:0]   diff;
   logic [2*RW-1:0] rad_ff, rad_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;

   // one root bit: bring down two radicand bits, try 4r+1
   always_comb begin
      rem_sh  = {rem_i, rad_i[2*RW-1 -: 2]};
      trial   = {root_i, 2'b01};
      take    = rem_sh >= trial;
      diff    = rem_sh - trial;
      rem_in  = take ? diff[RW-1:0] : rem_sh[RW-1:0];
      root_in = {root_i[RW-2:0], take};
      rad_in  = {rad_i[2*RW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

[src/bli_div_cell.sv]
`timescale 1ns / 1ps
module bli_div_cell #(
   parameter int DW = 21,
   parameter int QW = 30
) (
   input  logic          clock,
   input  logic [DW-1:0] rem_i,
   input  logic [DW-1:0] den_i,
   input  logic [QW-1:0] quot_i,
   output logic [DW-1:0] rem_o,
   output logic [DW-1:0] den_o,
   output logic [QW-1:0] quot_o
);

   logic [DW:0]   rem_sh;
   logic [DW:0]   diff;
   logic          take;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff;
   logic [QW-1:0] quot_ff, quot_in;

   // one restoring quotient bit
   always_comb begin
      rem_sh  = {rem_i, 1'b0};
      take    = rem_sh >= {1'b0, den_i};
      diff    = rem_sh - {1'b0, den_i};
      rem_in  = take ? diff[DW-1:0] : rem_sh[DW-1:0];
      quot_in = {quot_i[QW-2:0], take};
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_i;
      quot_ff <= quot_in;
   end

   assign rem_o  = rem_ff;
   assign den_o  = den_ff;
   assign quot_o = quot_ff;

endmodule

[src/bli_cordic_cell.sv]
`timescale 1ns / 1ps
module bli_cordic_cell
   import bli_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic                     clock,
   input  logic signed [CORD_W-1:0] x_i,
   input  logic signed [CORD_W-1:0] y_i,
   input  logic signed [CORD_W-1:0] z_i,
   output logic signed [CORD_W-1:0] x_o,
   output logic signed [CORD_W-1:0] y_o,
   output logic signed [CORD_W-1:0] z_o
);

   localparam logic signed [CORD_W-1:0] ANG = {{(CORD_W-30){1'b0}}, bli_atan(IDX)};

   logic signed [CORD_W-1:0] xs, ys;
   logic signed [CORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;

   // vectoring step: drive y toward zero
   always_comb begin
      xs = x_i >>> IDX;
      ys = y_i >>> IDX;
      if (!y_i[CORD_W-1]) begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + ANG;
      end else begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - ANG;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;

endmodule

[src/bli_asin_lane.sv]
`timescale 1ns / 1ps
module bli_asin_lane
   import bli_pkg::*;
#(
   parameter int CORDIC_STAGES = 18
) (
   input  logic                     clock,
   input  logic signed [T_W-1:0]    t_i,
   output logic signed [CORD_W-1:0] z_o
);

   logic [AROOT_W-1:0]    t_abs;
   logic [ARAD_W-1:0]     sq_ff, sq_in;
   logic [ARAD_W-1:0]     rad_ff;
   logic signed [T_W-1:0] t_m_ff, t_r_ff, t_d;

   logic [ARAD_W-1:0]  s_rad  [AROOT_W+1];
   logic [AROOT_W-1:0] s_rem  [AROOT_W+1];
   logic [AROOT_W-1:0] s_root [AROOT_W+1];

   logic signed [CORD_W-1:0] c_x [CORDIC_STAGES+1];
   logic signed [CORD_W-1:0] c_y [CORDIC_STAGES+1];
   logic signed [CORD_W-1:0] c_z [CORDIC_STAGES+1];

   // t squared, then 1 - t^2 in q60
   always_comb begin
      t_abs = t_i[T_W-1] ? AROOT_W'(-t_i) : AROOT_W'(t_i);
      sq_in = ARAD_W'(t_abs) * ARAD_W'(t_abs);
   end

   always_ff @(posedge clock) begin
      sq_ff  <= sq_in;
      t_m_ff <= t_i;
      rad_ff <= Q60_ONE - sq_ff;
      t_r_ff <= t_m_ff;
   end

   // cosine term: one root bit per cell
   assign s_rad[0]  = rad_ff;
   assign s_rem[0]  = '0;
   assign s_root[0] = '0;

   for (genvar c = 0; c < AROOT_W; c++) begin : g_sqrt
      bli_sqrt_cell #(.RW(AROOT_W)) u_cell (
         .clock  (clock),
         .rad_i  (s_rad[c]),
         .rem_i  (s_rem[c]),
         .root_i (s_root[c]),
         .rad_o  (s_rad[c+1]),
         .rem_o  (s_rem[c+1]),
         .root_o (s_root[c+1])
      );
   end

   bli_delay #(.W(T_W), .DEPTH(AROOT_W)) u_t_dly (
      .clock (clock),
      .d_i   (t_r_ff),
      .q_o   (t_d)
   );

   // cordic row on (cos, sin)
   assign c_x[0] = signed'(CORD_W'(s_root[AROOT_W]));
   assign c_y[0] = CORD_W'(t_d);
   assign c_z[0] = '0;

   for (genvar c = 0; c < CORDIC_STAGES; c++) begin : g_cordic
      bli_cordic_cell #(.IDX(c)) u_cell (
         .clock (clock),
         .x_i   (c_x[c]),
         .y_i   (c_y[c]),
         .z_i   (c_z[c]),
         .x_o   (c_x[c+1]),
         .y_o   (c_y[c+1]),
         .z_o   (c_z[c+1])
      );
   end

   assign z_o = c_z[CORDIC_STAGES];

endmodule

[src/bli_checker.sv]
`timescale 1ns / 1ps
module bli_checker
   import bli_pkg::*;
#(
   parameter int CORDIC_STAGES = 18
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_valid,
   input logic signed [ANG_W-1:0] rsp_hip_yaw_angle,
   input logic signed [ANG_W-1:0] rsp_hip_pitch_angle,
   input logic signed [ANG_W-1:0] rsp_knee_angle,
   input logic signed [ANG_W-1:0] rsp_ankle_angle
);

   localparam int LAT   = bli_latency(CORDIC_STAGES);
   localparam int CNT_W = $clog2(LAT + 1);

   logic [CNT_W-1:0]        warm_ff;
   logic                    warm;
   logic                    inner;
   logic signed [ANG_W-1:0] ankle_exp;

   // cycles since reset, saturating at the pipeline depth
   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff <= '0;
      end else if (!warm) begin
         warm_ff <= warm_ff + 1'b1;
      end
   end

   assign warm = warm_ff == CNT_W'(LAT);

   // ankle relation holds exactly when pitch and knee did not clip
   assign inner = (rsp_knee_angle != OUT_MAX[ANG_W-1:0])
               && (rsp_knee_angle != OUT_MIN[ANG_W-1:0])
               && (rsp_hip_pitch_angle != OUT_MAX[ANG_W-1:0])
               && (rsp_hip_pitch_angle != OUT_MIN[ANG_W-1:0]);
   assign ankle_exp = bli_sat(-(ACC_W+1)'(rsp_knee_angle) - (ACC_W+1)'(rsp_hip_pitch_angle));

   a_yaw_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hip_yaw_angle == '0)
      else $error("hip yaw not zero");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      warm |-> (rsp_valid == $past(start && !busy, LAT)))
      else $error("result beat not at fixed latency");

   a_ankle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && inner) |-> rsp_ankle_angle == ankle_exp)
      else $error("ankle does not match knee and pitch");

endmodule

bind biped_leg_inverse_kinematics bli_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_bli_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_hip_yaw_angle   (rsp_hip_yaw_angle),
   .rsp_hip_pitch_angle (rsp_hip_pitch_angle),
   .rsp_knee_angle      (rsp_knee_angle),
   .rsp_ankle_angle     (rsp_ankle_angle)
);
